[hdl/ctt_pkg.sv]
// Shared types and constants for the config text tokenizer.
// No dependencies; every module file imports this package.
package ctt_pkg;

  // Default depth of the result queue between front and back (power of two, >= 4)
  localparam int CTT_QUEUE_DEPTH = 4;

  // Token kinds as seen on the result channel
  typedef enum logic [2:0] {
    KIND_END    = 3'd0,
    KIND_LBRACE = 3'd1,
    KIND_RBRACE = 3'd2,
    KIND_SEMI   = 3'd3,
    KIND_STRING = 3'd4,
    KIND_IDENT  = 3'd5
  } kind_t;

  // Characters with a meaning to the lexer
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       has;
    logic       last;
  } token_t;

  // Front to queue: up to two result words per accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    token_t     item0;
    token_t     item1;
  } push_t;

endpackage

[hdl/ctt_text_if.sv]
// Byte channel carrying config text into the tokenizer.
// Standalone valid/ready interface; no package needed.
interface ctt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source(output valid, output text_byte, input ready);
  modport sink(input valid, input text_byte, output ready);
endinterface

[hdl/ctt_token_if.sv]
// Result channel carrying token words out of the tokenizer.
// Standalone valid/ready interface; no package needed.
interface ctt_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] value_byte;
  logic       has_byte;
  logic       token_last;

  modport source(output valid, output token_kind, output value_byte,
                 output has_byte, output token_last, input ready);
  modport sink(input valid, input token_kind, input value_byte,
               input has_byte, input token_last, output ready);
endinterface

[hdl/config_text_tokenizer_core.sv]
// Config text tokenizer. Takes one text byte per cycle on the text channel
// and emits tokens as runs of words on the token channel, each token closed
// by a word with token_last set. A byte is taken whenever the result queue
// has room for two words, so text streams in at one byte per clock; words
// leave at one per clock while the token channel is ready. A byte that closes
// an identifier or string and emits a word of its own pushes two words. Words
// pass the queue, then the output register. QUEUE_DEPTH sets the queue size
// (power of two, at least 4); a deeper queue absorbs longer output stalls.
// Depends on ctt_pkg, ctt_text_if, ctt_token_if, ctt_front, ctt_queue, ctt_back.
module config_text_tokenizer_core import ctt_pkg::*; #(
  parameter int QUEUE_DEPTH = CTT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  ctt_text_if.sink     text,
  ctt_token_if.source  token
);

  push_t  push;
  logic   room;
  logic   head_valid;
  token_t head;
  logic   pop;

  // Classify bytes and track lexer mode
  ctt_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .room (room),
    .push (push)
  );

  // Decouple front from back
  ctt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Drive the token channel
  ctt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .token      (token)
  );

endmodule

[hdl/ctt_front.sv]
// Front end: accepts text bytes, tracks the lexer mode, classifies each byte
// and pushes zero, one or two result words. Depends on ctt_pkg, ctt_text_if.
module ctt_front import ctt_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ctt_text_if.sink      text,
  input  logic          room,
  output push_t         push
);

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_IDENT   = 3'd4
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  mode_t      bt_mode;
  logic [7:0] b;
  logic       accept;
  logic       is_blank;
  logic       is_ident;
  logic       bt_emit;
  token_t     bt_item;
  token_t     r0;
  token_t     r1;
  logic [1:0] cnt;

  assign b          = text.text_byte;
  assign text.ready = room;
  assign accept     = text.valid && room;

  // Byte classes
  assign is_blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign is_ident = (b != CH_NUL) && !is_blank && (b != CH_LBRACE) &&
                    (b != CH_RBRACE) && (b != CH_SEMI) && (b != CH_QUOTE) &&
                    (b != CH_HASH);

  // Handling of a byte that arrives between tokens
  always_comb begin
    bt_mode = MODE_NORMAL;
    bt_emit = 1'b1;
    bt_item = '{kind: KIND_END, value: 8'h00, has: 1'b0, last: 1'b1};
    if (b == CH_NUL) begin
      bt_item.kind = KIND_END;
    end else if (is_blank) begin
      bt_emit = 1'b0;
    end else if (b == CH_HASH) begin
      bt_emit = 1'b0;
      bt_mode = MODE_COMMENT;
    end else if (b == CH_LBRACE) begin
      bt_item.kind = KIND_LBRACE;
    end else if (b == CH_RBRACE) begin
      bt_item.kind = KIND_RBRACE;
    end else if (b == CH_SEMI) begin
      bt_item.kind = KIND_SEMI;
    end else if (b == CH_QUOTE) begin
      bt_emit = 1'b0;
      bt_mode = MODE_STRING;
    end else begin
      bt_mode = MODE_IDENT;
      bt_item = '{kind: KIND_IDENT, value: b, has: 1'b1, last: 1'b0};
    end
  end

  // Per-mode result words and next mode
  always_comb begin
    mode_next = mode;
    cnt       = 2'd0;
    r0        = bt_item;
    r1        = '{kind: KIND_END, value: 8'h00, has: 1'b0, last: 1'b1};
    case (mode)
      MODE_IDENT: begin
        if (is_ident) begin
          cnt = 2'd1;
          r0  = '{kind: KIND_IDENT, value: b, has: 1'b1, last: 1'b0};
        end else begin
          // close the identifier, then treat the byte as between tokens
          r0        = '{kind: KIND_IDENT, value: 8'h00, has: 1'b0, last: 1'b1};
          r1        = bt_item;
          cnt       = bt_emit ? 2'd2 : 2'd1;
          mode_next = bt_mode;
        end
      end
      MODE_STRING: begin
        if (b == CH_NUL) begin
          r0        = '{kind: KIND_STRING, value: 8'h00, has: 1'b0, last: 1'b1};
          cnt       = 2'd2;
          mode_next = MODE_NORMAL;
        end else if (b == CH_QUOTE) begin
          r0        = '{kind: KIND_STRING, value: 8'h00, has: 1'b0, last: 1'b1};
          cnt       = 2'd1;
          mode_next = MODE_NORMAL;
        end else if (b == CH_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          r0  = '{kind: KIND_STRING, value: b, has: 1'b1, last: 1'b0};
          cnt = 2'd1;
        end
      end
      MODE_ESCAPE: begin
        if (b == CH_NUL) begin
          // drop the dangling backslash, close the string, then end
          r0        = '{kind: KIND_STRING, value: 8'h00, has: 1'b0, last: 1'b1};
          cnt       = 2'd2;
          mode_next = MODE_NORMAL;
        end else begin
          r0        = '{kind: KIND_STRING, value: b, has: 1'b1, last: 1'b0};
          cnt       = 2'd1;
          mode_next = MODE_STRING;
          if (b == CH_LOWER_N) begin
            r0.value = CH_NEWLINE;
          end else if (b == CH_LOWER_T) begin
            r0.value = CH_TAB;
          end
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NUL) begin
          cnt       = 2'd1;
          mode_next = MODE_NORMAL;
        end else if (b == CH_NEWLINE) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        cnt       = bt_emit ? 2'd1 : 2'd0;
        mode_next = bt_mode;
      end
    endcase
  end

  // Push only on an accepted byte
  assign push.cnt   = accept ? cnt : 2'd0;
  assign push.item0 = r0;
  assign push.item1 = r1;

  // Hold the lexer mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

[hdl/ctt_queue.sv]
// Result queue between front and back: takes up to two words per cycle,
// gives one per pop. Depends on ctt_pkg.
module ctt_queue import ctt_pkg::*; #(
  parameter int DEPTH = CTT_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   room,
  output logic   head_valid,
  output token_t head,
  input  logic   pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [AW-1:0]   wr_ptr1;
  logic            do_pop;

  assign wr_ptr1    = wr_ptr + AW'(1);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  // Leave space for the two words one byte may cause
  assign room       = (count <= CW'(DEPTH - 2));

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.item1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.cnt);
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push.cnt) - CW'(do_pop);
    end
  end

endmodule

[hdl/ctt_back.sv]
// Back end: output register that drains the queue one word per cycle onto
// the token channel while it is ready. Depends on ctt_pkg, ctt_token_if.
module ctt_back import ctt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  token_t       head,
  output logic         pop,
  ctt_token_if.source  token
);

  logic   out_valid;
  token_t out_word;

  assign pop = head_valid && (!out_valid || token.ready);

  // Hold control state of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || token.ready) begin
      out_valid <= head_valid;
    end
  end

  // Load payload when the register frees up
  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= head;
    end
  end

  assign token.valid      = out_valid;
  assign token.token_kind = out_word.kind;
  assign token.value_byte = out_word.value;
  assign token.has_byte   = out_word.has;
  assign token.token_last = out_word.last;

endmodule
